/* hdl/pmi_pkg.sv */
// Shared types, constants and step functions of the particle motion integrator.
package pmi_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_X_LOW  = 3'd1;
    localparam logic [2:0] CFG_X_HIGH = 3'd2;
    localparam logic [2:0] CFG_Y_LOW  = 3'd3;
    localparam logic [2:0] CFG_Y_HIGH = 3'd4;
    localparam logic [2:0] CFG_Z_LOW  = 3'd5;
    localparam logic [2:0] CFG_Z_HIGH = 3'd6;

    typedef logic [2:0][31:0] t_vec;
    typedef logic [2:0][61:0] t_num;
    typedef logic [2:0][63:0] t_rem;

    typedef struct packed {
        logic        en;
        logic        bnd;
        logic        over;
        t_vec        v;
        t_vec        p;
        logic [30:0] limit;
        logic [23:0] dt;
    } t_item;

    typedef struct packed {
        logic [31:0] xl;
        logic [31:0] xh;
        logic [31:0] yl;
        logic [31:0] yh;
        logic [31:0] zl;
        logic [31:0] zh;
    } t_bounds;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] root;
    } t_sq;

    typedef struct packed {
        logic [63:0] r;
        logic        q;
    } t_dv;

    function automatic t_sq sqrt_step(input logic [63:0] n, input logic [63:0] root,
                                      input logic [63:0] bitv);
        t_sq         s;
        logic [63:0] t;
        t = root + bitv;
        if (n >= t) begin
            s.n    = n - t;
            s.root = (root >> 1) + bitv;
        end else begin
            s.n    = n;
            s.root = root >> 1;
        end
        return s;
    endfunction

    function automatic t_dv div_step(input logic [63:0] r, input logic [63:0] d);
        t_dv s;
        if (r >= d) begin
            s.r = r - d;
            s.q = 1'b1;
        end else begin
            s.r = r;
            s.q = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [41:0] x);
        logic [31:0] y;
        if (x > 42'sd2147483647) begin
            y = 32'h7FFF_FFFF;
        end else if (x < -42'sd2147483648) begin
            y = 32'h8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

/* hdl/particle_motion_integrate_core.sv */
// Top level of the particle motion integrator: configuration, stall control, pipeline.
// One Euler step per word while enabled: the force is added to the velocity, which is scaled
// down to the speed limit when its length exceeds it; the position advances by velocity times
// time step and is optionally clamped to the bound registers. A new word is taken every cycle
// unless a finished word waits under output stall, which holds the whole pipeline. Stages:
// three front, the 32-stage square root and the 32-stage divider (each retiring one result
// bit per stage), four back. Configuration must be written while idle; this is not enforced.
module particle_motion_integrate_core
    import pmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_force_x,
    input  logic [31:0] i_force_y,
    input  logic [31:0] i_force_z,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [30:0] i_speed_limit,
    input  logic [23:0] i_time_step,
    input  logic        i_bounded,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic [31:0] o_new_vel_z,
    output logic [31:0] o_new_pos_x,
    output logic [31:0] o_new_pos_y,
    output logic [31:0] o_new_pos_z,
    output logic        o_speed_clipped
);

    logic        r_enable;
    t_bounds     r_bounds;
    logic        adv;
    logic        f_valid, s_valid, d_valid;
    t_item       f_item, s_item, d_item, b_item;
    logic [63:0] f_sumsq;
    t_num        f_num, s_num;
    logic [31:0] s_len;
    t_vec        d_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_bounds.xl <= 32'h8000_0000;
            r_bounds.xh <= 32'h7FFF_FFFF;
            r_bounds.yl <= 32'h8000_0000;
            r_bounds.yh <= 32'h7FFF_FFFF;
            r_bounds.zl <= 32'h8000_0000;
            r_bounds.zh <= 32'h7FFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_enable    <= i_cfg_data[0];
                CFG_X_LOW:  r_bounds.xl <= i_cfg_data;
                CFG_X_HIGH: r_bounds.xh <= i_cfg_data;
                CFG_Y_LOW:  r_bounds.yl <= i_cfg_data;
                CFG_Y_HIGH: r_bounds.yh <= i_cfg_data;
                CFG_Z_LOW:  r_bounds.zl <= i_cfg_data;
                CFG_Z_HIGH: r_bounds.zh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign adv     = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    pmi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_en    (r_enable),
        .i_valid (i_valid),
        .i_vel   ({i_vel_z, i_vel_y, i_vel_x}),
        .i_force ({i_force_z, i_force_y, i_force_x}),
        .i_pos   ({i_pos_z, i_pos_y, i_pos_x}),
        .i_limit (i_speed_limit),
        .i_dt    (i_time_step),
        .i_bnd   (i_bounded),
        .o_valid (f_valid),
        .o_item  (f_item),
        .o_sumsq (f_sumsq),
        .o_num   (f_num)
    );

    pmi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_item  (f_item),
        .i_n     (f_sumsq),
        .i_num   (f_num),
        .o_valid (s_valid),
        .o_item  (s_item),
        .o_num   (s_num),
        .o_len   (s_len)
    );

    pmi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_valid),
        .i_item  (s_item),
        .i_num   (s_num),
        .i_len   (s_len),
        .o_valid (d_valid),
        .o_item  (d_item),
        .o_q     (d_q)
    );

    pmi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (d_valid),
        .i_item   (d_item),
        .i_q      (d_q),
        .i_bounds (r_bounds),
        .o_valid  (o_valid),
        .o_item   (b_item)
    );

    assign o_new_vel_x     = b_item.v[0];
    assign o_new_vel_y     = b_item.v[1];
    assign o_new_vel_z     = b_item.v[2];
    assign o_new_pos_x     = b_item.p[0];
    assign o_new_pos_y     = b_item.p[1];
    assign o_new_pos_z     = b_item.p[2];
    assign o_speed_clipped = b_item.over;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a waiting output word");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output word valid right after reset");

    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(b_item)))
        else $error("held output word changed under stall");

endmodule

/* hdl/pmi_front.sv */
// Front stages: velocity update, squares, speed test and scaling numerators.
module pmi_front
    import pmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_vec        i_vel,
    input  t_vec        i_force,
    input  t_vec        i_pos,
    input  logic [30:0] i_limit,
    input  logic [23:0] i_dt,
    input  logic        i_bnd,
    output logic        o_valid,
    output t_item       o_item,
    output logic [63:0] o_sumsq,
    output t_num        o_num
);

    logic              r1_valid, r2_valid, r3_valid;
    t_item             r1_item, r2_item, r3_item;
    logic [2:0][63:0]  r2_sq;
    logic [61:0]       r2_lim2;
    t_num              r2_num, r3_num;
    logic [63:0]       r3_sumsq;
    t_item             n1_item;
    t_item             n3_item;
    logic [63:0]       n3_sumsq;
    logic [2:0][63:0]  n2_sq;
    t_num              n2_num;

    always_comb begin
        n1_item       = '0;
        n1_item.en    = i_en;
        n1_item.bnd   = i_bnd;
        n1_item.over  = 1'b0;
        n1_item.p     = i_pos;
        n1_item.limit = i_limit;
        n1_item.dt    = i_dt;
        for (int j = 0; j < 3; j++) begin
            if (i_en) begin
                n1_item.v[j] = sat32(42'($signed(i_vel[j])) + 42'($signed(i_force[j])));
            end else begin
                n1_item.v[j] = i_vel[j];
            end
        end
    end

    always_comb begin
        logic signed [63:0] sq;
        logic        [31:0] a;
        for (int j = 0; j < 3; j++) begin
            sq       = $signed(r1_item.v[j]) * $signed(r1_item.v[j]);
            n2_sq[j] = sq;
            a        = r1_item.v[j][31] ? (32'd0 - r1_item.v[j]) : r1_item.v[j];
            n2_num[j] = 62'(a) * 62'(r1_item.limit);
        end
    end

    assign n3_sumsq = r2_sq[0] + r2_sq[1] + r2_sq[2];

    always_comb begin
        n3_item      = r2_item;
        n3_item.over = r2_item.en && (n3_sumsq > {2'b00, r2_lim2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_item       <= n1_item;
            r2_item       <= r1_item;
            r2_sq         <= n2_sq;
            r2_lim2       <= 62'(r1_item.limit) * 62'(r1_item.limit);
            r2_num        <= n2_num;
            r3_item       <= n3_item;
            r3_sumsq      <= n3_sumsq;
            r3_num        <= r2_num;
        end
    end

    assign o_valid = r3_valid;
    assign o_item  = r3_item;
    assign o_sumsq = r3_sumsq;
    assign o_num   = r3_num;

endmodule

/* hdl/pmi_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module pmi_isqrt
    import pmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [63:0] i_n,
    input  t_num        i_num,
    output logic        o_valid,
    output t_item       o_item,
    output t_num        o_num,
    output logic [31:0] o_len
);

    logic        r_valid [SQRT_STEPS];
    t_item       r_item  [SQRT_STEPS];
    t_num        r_num   [SQRT_STEPS];
    logic [63:0] r_n     [SQRT_STEPS];
    logic [63:0] r_root  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
        logic        p_valid;
        t_item       p_item;
        t_num        p_num;
        logic [63:0] p_n;
        logic [63:0] p_root;
        t_sq         n_sq;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_item  = i_item;
            assign p_num   = i_num;
            assign p_n     = i_n;
            assign p_root  = '0;
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_item  = r_item[k-1];
            assign p_num   = r_num[k-1];
            assign p_n     = r_n[k-1];
            assign p_root  = r_root[k-1];
        end

        assign n_sq = sqrt_step(p_n, p_root, 64'd1 << (62 - 2 * k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k] <= p_item;
                r_num[k]  <= p_num;
                r_n[k]    <= n_sq.n;
                r_root[k] <= n_sq.root;
            end
        end
    end

    assign o_valid = r_valid[SQRT_STEPS-1];
    assign o_item  = r_item[SQRT_STEPS-1];
    assign o_num   = r_num[SQRT_STEPS-1];
    assign o_len   = r_root[SQRT_STEPS-1][31:0];

endmodule

/* hdl/pmi_div.sv */
// Pipelined restoring divider for the three axes, one quotient bit per stage.
module pmi_div
    import pmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  t_item       i_item,
    input  t_num        i_num,
    input  logic [31:0] i_len,
    output logic        o_valid,
    output t_item       o_item,
    output t_vec        o_q
);

    logic        r_valid [DIV_STEPS];
    t_item       r_item  [DIV_STEPS];
    logic [31:0] r_len   [DIV_STEPS];
    t_rem        r_rem   [DIV_STEPS];
    t_vec        r_q     [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic        p_valid;
        t_item       p_item;
        logic [31:0] p_len;
        t_rem        p_rem;
        t_vec        p_q;
        t_rem        n_rem;
        t_vec        n_q;
        logic [63:0] dsh;

        if (k == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_item  = i_item;
            assign p_len   = i_len;
            assign p_q     = '0;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign p_rem[j] = {2'b00, i_num[j]};
            end
        end else begin : g_next
            assign p_valid = r_valid[k-1];
            assign p_item  = r_item[k-1];
            assign p_len   = r_len[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_q     = r_q[k-1];
        end

        assign dsh = {32'd0, p_len} << (DIV_STEPS - 1 - k);

        always_comb begin
            t_dv s;
            for (int j = 0; j < 3; j++) begin
                s        = div_step(p_rem[j], dsh);
                n_rem[j] = s.r;
                n_q[j]   = p_q[j] | (32'(s.q) << (DIV_STEPS - 1 - k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_item[k] <= p_item;
                r_len[k]  <= p_len;
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_item  = r_item[DIV_STEPS-1];
    assign o_q     = r_q[DIV_STEPS-1];

endmodule

/* hdl/pmi_back.sv */
// Back stages: velocity select, position step, saturation and box clamp.
module pmi_back
    import pmi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  logic    i_valid,
    input  t_item   i_item,
    input  t_vec    i_q,
    input  t_bounds i_bounds,
    output logic    o_valid,
    output t_item   o_item
);

    logic                    r1_valid, r2_valid, r3_valid, r4_valid;
    t_item                   r1_item, r2_item, r3_item, r4_item;
    logic [2:0][56:0]        r2_prod;
    t_item                   n1_item, n3_item, n4_item;
    logic [2:0][56:0]        n2_prod;

    always_comb begin
        n1_item = i_item;
        for (int j = 0; j < 3; j++) begin
            if (i_item.over) begin
                n1_item.v[j] = i_item.v[j][31] ? (32'd0 - i_q[j]) : i_q[j];
            end
        end
    end

    always_comb begin
        logic signed [56:0] pr;
        for (int j = 0; j < 3; j++) begin
            pr         = $signed(r1_item.v[j]) * $signed({1'b0, r1_item.dt});
            n2_prod[j] = pr;
        end
    end

    always_comb begin
        logic signed [40:0] stepv;
        logic signed [41:0] sum;
        n3_item = r2_item;
        for (int j = 0; j < 3; j++) begin
            stepv = 41'($signed(r2_prod[j]) >>> 16);
            sum   = 42'($signed(r2_item.p[j])) + 42'(stepv);
            if (r2_item.en) begin
                n3_item.p[j] = sat32(sum);
            end
        end
    end

    always_comb begin
        logic signed [31:0] px, py, pz;
        n4_item = r3_item;
        px = $signed(r3_item.p[0]);
        py = $signed(r3_item.p[1]);
        pz = $signed(r3_item.p[2]);
        if (r3_item.en && r3_item.bnd) begin
            if (px < $signed(i_bounds.xl)) px = $signed(i_bounds.xl);
            if (px > $signed(i_bounds.xh)) px = $signed(i_bounds.xh);
            if (py > $signed(i_bounds.yh)) py = $signed(i_bounds.yh);
            if (py < $signed(i_bounds.yl)) py = $signed(i_bounds.yl);
            if (pz < $signed(i_bounds.zl)) pz = $signed(i_bounds.zl);
            if (pz > $signed(i_bounds.zh)) pz = $signed(i_bounds.zh);
        end
        n4_item.p[0] = px;
        n4_item.p[1] = py;
        n4_item.p[2] = pz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_item <= n1_item;
            r2_item <= r1_item;
            r2_prod <= n2_prod;
            r3_item <= n3_item;
            r4_item <= n4_item;
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;

endmodule
